FILE: rtl/core/dtd_pkg.sv
// shared types, constants and pair table of the digram text decompressor
`default_nettype none
package dtd_pkg;

  localparam int unsigned MAX_CAPACITY = 1024;
  localparam int unsigned CAP_W        = 11;
  localparam int unsigned LEN_W        = 10;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PAIR_ENTRIES = 144;

  localparam logic [7:0]       ESC_BYTE    = 8'h1B;
  localparam logic [7:0]       ESC_OFFSET  = 8'h7F;
  localparam logic [7:0]       SECOND_BASE = 8'd16;
  localparam logic [CAP_W-1:0] CAP_MIN     = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX     = CAP_W'(MAX_CAPACITY);
  localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(1024);

  localparam logic [PAIR_ENTRIES*8-1:0] PAIR_TEXT = {
    " etainosrlhcdupm",
    "tasio wb", " rnsdalm", "h ieoras", "nrtlc sy",
    "nstcloer", " dtgesio", "nr ufmsw", " tep.ica",
    "e oiadur", " laeiyod", "eia otru", "etoakhlr",
    " eiu,.oa", "nsrctlai", "leoiratp", "eaoip bm"
  };

  typedef enum logic [1:0] {
    OP_ONE,
    OP_PAIR,
    OP_END,
    OP_ESC_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] ch0;
    logic [7:0] ch1;
  } op_t;

  // first entry of the text sits in the top byte
  function automatic logic [7:0] pair_char(input logic [7:0] idx);
    logic [10:0] pos;
    pos = {3'd0, 8'(PAIR_ENTRIES - 1) - idx} << 3;
    return PAIR_TEXT[pos +: 8];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dtd_ifs.sv
// valid/ready channel interfaces for compressed bytes and decoded results
`default_nettype none
interface dtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

interface dtd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_end;
  logic [9:0] out_length;
  logic       truncated;
  logic       last_of_item;
  modport source(output valid, output out_char, output is_end, output out_length,
                 output truncated, output last_of_item, input ready);
  modport sink(input valid, input out_char, input is_end, input out_length,
               input truncated, input last_of_item, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dtd_front.sv
// front end: accepts bytes, tracks escapes and turns each byte but an escape prefix into an op
`default_nettype none
module dtd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  dtd_in_if.sink            in_ch,
  input  wire logic         q_full,
  output logic              q_push,
  output dtd_pkg::op_t      q_op
);
  import dtd_pkg::*;

  logic       esc_r;
  logic       esc_nxt;
  logic       accept;
  logic [7:0] b;
  logic [6:0] v;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign v           = b[6:0];

  always_comb begin
    esc_nxt    = esc_r;
    q_push     = 1'b0;
    q_op.kind  = OP_ONE;
    q_op.ch0   = b;
    q_op.ch1   = 8'd0;
    if (esc_r) begin
      // escape operand: offset char, and a zero operand also ends the string
      q_op.ch0  = b + ESC_OFFSET;
      q_op.kind = (b == 8'd0) ? OP_ESC_END : OP_ONE;
      q_push    = accept;
      if (accept) begin
        esc_nxt = 1'b0;
      end
    end else if (b == 8'd0) begin
      q_op.kind = OP_END;
      q_push    = accept;
    end else if (b[7]) begin
      q_op.kind = OP_PAIR;
      q_op.ch0  = pair_char({4'd0, v[6:3]});
      q_op.ch1  = pair_char({1'b0, v} + SECOND_BASE);
      q_push    = accept;
    end else if (b == ESC_BYTE) begin
      if (accept) begin
        esc_nxt = 1'b1;
      end
    end else begin
      q_push = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dtd_queue.sv
// short op queue between front and back end
`default_nettype none
module dtd_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire dtd_pkg::op_t push_op,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output dtd_pkg::op_t      head_op
);
  import dtd_pkg::*;

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dtd_back.sv
// back end: applies the capacity limit, counts characters, drives results
`default_nettype none
module dtd_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [dtd_pkg::CAP_W-1:0] capacity,
  input  wire logic                      head_valid,
  input  wire dtd_pkg::op_t              head_op,
  output logic                           pop,
  dtd_out_if.source                      out_ch
);
  import dtd_pkg::*;

  logic [LEN_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             second_r, second_nxt;

  logic             out_valid_r;
  logic [7:0]       char_r;
  logic             end_r;
  logic [LEN_W-1:0] len_r;
  logic             trunc_r;
  logic             last_r;

  logic [CAP_W-1:0] cap_eff;
  logic [LEN_W-1:0] limit;
  logic             room;
  logic             last_room;
  logic             load;
  logic             res_valid;
  logic [7:0]       res_char;
  logic             res_end;
  logic [LEN_W-1:0] res_len;
  logic             res_trunc;
  logic             res_last;

  always_comb begin
    if (capacity < CAP_MIN) begin
      cap_eff = CAP_MIN;
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
  end

  assign limit     = LEN_W'(cap_eff - CAP_W'(1));
  assign room      = count_r < limit;
  // this character fills the last free slot
  assign last_room = ({1'b0, count_r} + CAP_W'(1)) >= {1'b0, limit};
  assign load      = !out_valid_r || out_ch.ready;

  always_comb begin
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    second_nxt = second_r;
    pop        = 1'b0;
    res_valid  = 1'b0;
    res_char   = head_op.ch0;
    res_end    = 1'b0;
    res_len    = '0;
    res_trunc  = 1'b0;
    res_last   = 1'b1;
    if (head_valid && load) begin
      unique case (head_op.kind)
        OP_ONE: begin
          pop = 1'b1;
          if (room) begin
            res_valid = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_PAIR: begin
          if (second_r) begin
            res_valid  = 1'b1;
            res_char   = head_op.ch1;
            count_nxt  = count_r + 1'b1;
            second_nxt = 1'b0;
            pop        = 1'b1;
          end else if (!room) begin
            ovf_nxt = 1'b1;
            pop     = 1'b1;
          end else begin
            res_valid = 1'b1;
            res_last  = last_room;
            count_nxt = count_r + 1'b1;
            if (last_room) begin
              ovf_nxt = 1'b1;
              pop     = 1'b1;
            end else begin
              second_nxt = 1'b1;
            end
          end
        end
        OP_END: begin
          res_valid = 1'b1;
          res_char  = 8'd0;
          res_end   = 1'b1;
          res_len   = count_r;
          res_trunc = ovf_r;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          pop       = 1'b1;
        end
        OP_ESC_END: begin
          if (second_r || !room) begin
            // end result; a dropped escape char shows up as truncation
            res_valid  = 1'b1;
            res_char   = 8'd0;
            res_end    = 1'b1;
            res_len    = count_r;
            res_trunc  = ovf_r || !second_r;
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
            second_nxt = 1'b0;
            pop        = 1'b1;
          end else begin
            res_valid  = 1'b1;
            res_last   = 1'b0;
            count_nxt  = count_r + 1'b1;
            second_nxt = 1'b1;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      second_r <= second_nxt;
      if (load) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      char_r  <= res_char;
      end_r   <= res_end;
      len_r   <= res_len;
      trunc_r <= res_trunc;
      last_r  <= res_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_char     = char_r;
  assign out_ch.is_end       = end_r;
  assign out_ch.out_length   = len_r;
  assign out_ch.truncated    = trunc_r;
  assign out_ch.last_of_item = last_r;

`ifndef ASSERT_OFF
  a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> head_valid)
    else $error("second step pending without an op at the queue head");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_valid && res_end) |=> (count_r == '0 && !ovf_r && !second_r))
    else $error("string state not cleared after end result");

  a_char_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_valid && !res_end) |=> (count_r == $past(count_r) + 1'b1))
    else $error("character result did not advance the count");

  a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !end_r) |-> (len_r == '0 && !trunc_r))
    else $error("character result carries end fields");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/digram_text_decompressor_unit.sv
// Digram text decompressor: compressed byte stream in, decoded characters out.
//
// in_ch carries one compressed byte per transaction; zero ends the string.
// out_ch carries one result per transaction: a character, or the end result
// with the string length and a truncation flag; last_of_item marks the final
// result caused by an input byte. cfg_we/cfg_wdata write the capacity, which
// the user must see is changed only while no string byte is in flight; the
// block does not enforce this. out_ch.valid rises once the accepted byte's op
// has passed through the op queue and the registered result stage. A pair
// byte and an escape-then-zero give two results each, all other bytes one,
// since the back end makes one result per cycle while out_ch is not stalled;
// so the sustained rate is one byte per cycle for plain text.
// A lone escape byte gives no result.
// A two-entry op queue sits between the byte decoder and the result stage,
// so input is still taken while a result waits on a stalled receiver, until
// the queue fills. Output holds steady while out_ch.ready is low.
// Reset clears the escape, count and queue state and sets capacity to 1024.
`default_nettype none
module digram_text_decompressor_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  dtd_in_if.sink                         in_ch,
  dtd_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [dtd_pkg::CAP_W-1:0] cfg_wdata
);
  import dtd_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic             q_full;
  logic             q_push;
  op_t              q_push_op;
  logic             q_pop;
  logic             q_head_valid;
  op_t              q_head_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  dtd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (q_push_op)
  );

  dtd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  dtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (capacity_r),
    .head_valid (q_head_valid),
    .head_op    (q_head_op),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
